@@ rtl/core/fcc_pkg.sv @@
// ============================================================================
// fcc_pkg: shared constants for the fluid cell colorizer
// Mode codes, field widths, pipeline depth and fixed-point constants.
// ============================================================================
`default_nettype none

package fcc_pkg;

	// field widths
	localparam int DENS_W  = 24;
	localparam int VEL_W   = 32;
	localparam int CHAN_W  = 8;
	localparam int MODE_W  = 2;
	localparam int WHOLE_W = DENS_W - 8;   // integer part of Q15.8

	// color mode codes
	localparam logic [MODE_W-1:0] MODE_WHITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HUE   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_VEL   = 2'd2;

	// hue sectors of the six-sector HSV rule
	localparam logic [2:0] SEC_RED_YEL = 3'd0;
	localparam logic [2:0] SEC_YEL_GRN = 3'd1;
	localparam logic [2:0] SEC_GRN_CYN = 3'd2;
	localparam logic [2:0] SEC_CYN_BLU = 3'd3;
	localparam logic [2:0] SEC_BLU_MAG = 3'd4;

	// cycles from accepted item to result strobe
	localparam int LATENCY = 6;

	// velocity map: (v*5100 + 255*2^20) >> 21
	localparam int                PROD_W   = 46;
	localparam logic signed [13:0] VEL_GAIN = 14'sd5100;
	localparam logic signed [PROD_W-1:0] VEL_BIAS = PROD_W'(255) <<< 20;

	// hue wrap: bias to a positive value that is a multiple of 360
	localparam logic signed [17:0] HUE_OFFSET = 18'sd33120;
	// floor(x/45) for x < 2^14 as (x*RECIP_45) >> 20
	localparam logic [14:0] RECIP_45 = 15'd23302;
	// floor(h/60) for h < 360 as (h*RECIP_60) >> 16
	localparam logic [10:0] RECIP_60 = 11'd1093;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

endpackage

`default_nettype wire

@@ rtl/core/fluid_cell_colorizer_core.sv @@
// ============================================================================
// fluid_cell_colorizer_core: fluid cell to RGBA color
// Maps density or velocity of one cell to a color, selected by mode_q.
// ============================================================================
//
// Usage:
//   Input channel: an item (cell_density, velocity_x, velocity_y) is taken
//   at each rising edge with start high and busy low. busy never rises, so
//   one item can be taken every cycle.
//   Result channel: done is high for exactly one cycle with red, green,
//   blue and alpha valid. Throughput is one item per cycle, set by a
//   six-stage pipeline (input, multiply, wrap/clamp, hue subtract,
//   sector, color select).
//   Configuration: cfg_data is written to mode_q at an edge with
//   cfg_valid and cfg_ready high; cfg_ready is always high. Each item
//   carries the mode that was current when it was taken.
//   Reset: arst_n low clears all stage valid bits and sets mode_q to 0.
//   The receiver cannot stall; nothing holds the pipeline.
//
`default_nettype none

module fluid_cell_colorizer_core
	import fcc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// item in
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic signed [DENS_W-1:0] cell_density,
	input  wire logic signed [VEL_W-1:0]  velocity_x,
	input  wire logic signed [VEL_W-1:0]  velocity_y,
	// result out
	output logic                          done,
	output logic [CHAN_W-1:0]             red,
	output logic [CHAN_W-1:0]             green,
	output logic [CHAN_W-1:0]             blue,
	output logic [CHAN_W-1:0]             alpha,
	// config
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [MODE_W-1:0]        cfg_data
);

	// clamp of one scaled velocity to 0..255
	function automatic logic [CHAN_W-1:0] vel_chan(input logic signed [PROD_W-1:0] num);
		logic [CHAN_W-1:0] res;
		if (num <= 0)
			res = '0;
		else if (num[PROD_W-1:21] > (PROD_W-21)'(CHAN_MAX))
			res = CHAN_MAX;
		else
			res = num[28:21];
		return res;
	endfunction

	logic [MODE_W-1:0] mode_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_WHITE;
		else if (cfg_valid && cfg_ready)
			mode_q <= cfg_data;
	end

	// ---------------- stage 1: input register ----------------
	logic                     vld_s1;
	logic [MODE_W-1:0]        mode_s1;
	logic signed [DENS_W-1:0] dens_s1;
	logic signed [VEL_W-1:0]  velx_s1, vely_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1 <= mode_q;
			dens_s1 <= cell_density;
			velx_s1 <= velocity_x;
			vely_s1 <= velocity_y;
		end
	end

	// ---------------- stage 2: integer density, velocity products ----------------
	logic                      vld_s2;
	logic [MODE_W-1:0]         mode_s2;
	logic signed [WHOLE_W-1:0] whole_s2;
	logic signed [PROD_W-1:0]  prodx_s2, prody_s2;
	logic signed [WHOLE_W-1:0] whole_c;

	// truncate toward zero: round floor up when negative with fraction
	assign whole_c = dens_s1[DENS_W-1:8]
		+ WHOLE_W'(dens_s1[DENS_W-1] && (dens_s1[7:0] != 8'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		mode_s2  <= mode_s1;
		whole_s2 <= whole_c;
		prodx_s2 <= velx_s1 * VEL_GAIN;
		prody_s2 <= vely_s1 * VEL_GAIN;
	end

	// ---------------- stage 3: hue bias and quotient, clamps ----------------
	logic                vld_s3;
	logic [MODE_W-1:0]   mode_s3;
	logic [16:0]         hue_u_s3;
	logic [7:0]          quo_s3;
	logic [CHAN_W-1:0]   wht_a_s3, vel_r_s3, vel_g_s3;
	logic signed [17:0]  hue_sum;
	logic [28:0]         quo_prod;
	logic [CHAN_W-1:0]   wht_a_c;

	// biased hue is positive and keeps the same residue mod 360
	assign hue_sum  = 18'(whole_s2) + HUE_OFFSET;
	assign quo_prod = hue_sum[16:3] * RECIP_45;

	always_comb begin
		if (whole_s2 < 0)
			wht_a_c = '0;
		else if (whole_s2 > WHOLE_W'(CHAN_MAX))
			wht_a_c = CHAN_MAX;
		else
			wht_a_c = whole_s2[CHAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		mode_s3  <= mode_s2;
		hue_u_s3 <= hue_sum[16:0];
		quo_s3   <= quo_prod[27:20];
		wht_a_s3 <= wht_a_c;
		vel_r_s3 <= vel_chan(prodx_s2 + VEL_BIAS);
		vel_g_s3 <= vel_chan(prody_s2 + VEL_BIAS);
	end

	// ---------------- stage 4: hue = biased value mod 360 ----------------
	logic              vld_s4;
	logic [MODE_W-1:0] mode_s4;
	logic [8:0]        hue_s4;
	logic [CHAN_W-1:0] wht_a_s4, vel_r_s4, vel_g_s4;
	logic [16:0]       hue_diff;

	assign hue_diff = hue_u_s3 - 17'(quo_s3) * 17'd360;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		mode_s4  <= mode_s3;
		hue_s4   <= hue_diff[8:0];
		wht_a_s4 <= wht_a_s3;
		vel_r_s4 <= vel_r_s3;
		vel_g_s4 <= vel_g_s3;
	end

	// ---------------- stage 5: sector = hue / 60 ----------------
	logic              vld_s5;
	logic [MODE_W-1:0] mode_s5;
	logic [8:0]        hue_s5;
	logic [2:0]        sec_s5;
	logic [CHAN_W-1:0] wht_a_s5, vel_r_s5, vel_g_s5;
	logic [19:0]       sec_prod;

	assign sec_prod = hue_s4 * RECIP_60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		mode_s5  <= mode_s4;
		hue_s5   <= hue_s4;
		sec_s5   <= sec_prod[18:16];
		wht_a_s5 <= wht_a_s4;
		vel_r_s5 <= vel_r_s4;
		vel_g_s5 <= vel_g_s4;
	end

	// ---------------- stage 6: ramps and color select ----------------
	logic              vld_s6;
	logic [CHAN_W-1:0] red_s6, green_s6, blue_s6, alpha_s6;
	logic [8:0]        hue_rem;
	logic [5:0]        rem;
	logic [9:0]        rem17;
	logic [CHAN_W-1:0] up, down;
	logic [CHAN_W-1:0] r_c, g_c, b_c, a_c;

	// r*255/60 = r*17/4, floor for the rising ramp, ceil for the falling one
	assign hue_rem = hue_s5 - 9'(sec_s5) * 9'd60;
	assign rem     = hue_rem[5:0];
	assign rem17   = {rem, 4'b0000} + 10'(rem);
	assign up      = rem17[9:2];
	assign down    = CHAN_MAX - 8'((11'(rem17) + 11'd3) >> 2);

	always_comb begin
		r_c = CHAN_MAX;
		g_c = CHAN_MAX;
		b_c = CHAN_MAX;
		a_c = CHAN_MAX;
		case (mode_s5)
			MODE_WHITE: begin
				a_c = wht_a_s5;
			end
			MODE_HUE: begin
				case (sec_s5)
					SEC_RED_YEL: begin r_c = CHAN_MAX; g_c = up;       b_c = '0;       end
					SEC_YEL_GRN: begin r_c = down;     g_c = CHAN_MAX; b_c = '0;       end
					SEC_GRN_CYN: begin r_c = '0;       g_c = CHAN_MAX; b_c = up;       end
					SEC_CYN_BLU: begin r_c = '0;       g_c = down;     b_c = CHAN_MAX; end
					SEC_BLU_MAG: begin r_c = up;       g_c = '0;       b_c = CHAN_MAX; end
					default:     begin r_c = CHAN_MAX; g_c = '0;       b_c = down;     end
				endcase
			end
			MODE_VEL: begin
				r_c = vel_r_s5;
				g_c = vel_g_s5;
			end
			default: begin
				// unused code: opaque white
				r_c = CHAN_MAX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else
			vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		red_s6   <= r_c;
		green_s6 <= g_c;
		blue_s6  <= b_c;
		alpha_s6 <= a_c;
	end

	assign done  = vld_s6;
	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;
	assign alpha = alpha_s6;

endmodule

`default_nettype wire

@@ rtl/core/fcc_checker.sv @@
// ============================================================================
// fcc_checker: port-level checks for the fluid cell colorizer
// Item/result pairing over the fixed latency and color sanity rules.
// ============================================================================
`default_nettype none

module fcc_checker
	import fcc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic [CHAN_W-1:0] red,
	input wire logic [CHAN_W-1:0] green,
	input wire logic [CHAN_W-1:0] blue,
	input wire logic [CHAN_W-1:0] alpha
);

	// every accepted item gives a result after the fixed latency
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
	else $error("accepted item gave no result");

	// no result without an item accepted the fixed latency earlier
	a_result_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
	else $error("result without accepted item");

	// only the white mode gives alpha below 255, and then the color is white
	a_alpha_white: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (alpha != CHAN_MAX)) |->
			(red == CHAN_MAX && green == CHAN_MAX && blue == CHAN_MAX))
	else $error("translucent result is not white");

	// every mode keeps at least one channel at full scale
	a_one_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red == CHAN_MAX || green == CHAN_MAX || blue == CHAN_MAX))
	else $error("no color channel at full scale");

endmodule

bind fluid_cell_colorizer_core fcc_checker u_fcc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.red   (red),
	.green (green),
	.blue  (blue),
	.alpha (alpha)
);

`default_nettype wire
